// ----- src/clns_pkg.sv -----
// types, constants and microprogram table of the character lcd nibble sequencer
`default_nettype none
package clns_pkg;

    localparam int          PC_W        = 5;
    localparam int          WAIT_W      = 15;

    localparam logic [7:0]  CMD_CLEAR   = 8'h01;
    localparam logic [7:0]  CMD_HOME    = 8'h02;
    localparam logic [7:0]  CMD_SET_ADDR = 8'h80;

    localparam logic [WAIT_W-1:0] WAIT_EN_HIGH  = 15'd1;
    localparam logic [WAIT_W-1:0] WAIT_EN_LOW   = 15'd50;
    localparam logic [WAIT_W-1:0] WAIT_POWER_ON = 15'd20000;
    localparam logic [WAIT_W-1:0] WAIT_WAKE_ONE = 15'd5050;  // low step plus 5000
    localparam logic [WAIT_W-1:0] WAIT_WAKE_TWO = 15'd200;   // low step plus 150
    localparam logic [WAIT_W-1:0] WAIT_SLOW     = 15'd2050;  // low step plus 2000

    localparam logic [PC_W-1:0] PC_INIT = 5'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 5'd25;

    typedef enum logic [1:0] {
        KIND_INIT   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_CURSOR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_HIGH  = 2'd1,
        SRC_LOW   = 2'd2
    } t_nib_src;

    typedef enum logic [2:0] {
        W_EN_HIGH  = 3'd0,
        W_EN_LOW   = 3'd1,
        W_POWER_ON = 3'd2,
        W_WAKE_ONE = 3'd3,
        W_WAKE_TWO = 3'd4,
        W_SLOW     = 3'd5,
        W_COND     = 3'd6   // slow wait only when the latched command is clear or home
    } t_wait_sel;

    typedef struct packed {
        t_nib_src  src;
        logic [3:0] nib;
        logic      en;
        t_wait_sel wsel;
        logic      last;
    } t_uword;

    function automatic t_uword mk(input t_nib_src src, input logic [3:0] nib,
                                  input logic en, input t_wait_sel wsel,
                                  input logic last);
        t_uword w;
        w.src  = src;
        w.nib  = nib;
        w.en   = en;
        w.wsel = wsel;
        w.last = last;
        return w;
    endfunction

    function automatic t_uword urom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:  w = mk(SRC_CONST, 4'h0, 1'b0, W_POWER_ON, 1'b0);
            5'd1:  w = mk(SRC_CONST, 4'h3, 1'b1, W_EN_HIGH,  1'b0);
            5'd2:  w = mk(SRC_CONST, 4'h3, 1'b0, W_WAKE_ONE, 1'b0);
            5'd3:  w = mk(SRC_CONST, 4'h3, 1'b1, W_EN_HIGH,  1'b0);
            5'd4:  w = mk(SRC_CONST, 4'h3, 1'b0, W_WAKE_TWO, 1'b0);
            5'd5:  w = mk(SRC_CONST, 4'h3, 1'b1, W_EN_HIGH,  1'b0);
            5'd6:  w = mk(SRC_CONST, 4'h3, 1'b0, W_EN_LOW,   1'b0);
            5'd7:  w = mk(SRC_CONST, 4'h2, 1'b1, W_EN_HIGH,  1'b0);
            5'd8:  w = mk(SRC_CONST, 4'h2, 1'b0, W_EN_LOW,   1'b0);
            // function set, four-bit bus, two lines
            5'd9:  w = mk(SRC_CONST, 4'h2, 1'b1, W_EN_HIGH,  1'b0);
            5'd10: w = mk(SRC_CONST, 4'h2, 1'b0, W_EN_LOW,   1'b0);
            5'd11: w = mk(SRC_CONST, 4'h8, 1'b1, W_EN_HIGH,  1'b0);
            5'd12: w = mk(SRC_CONST, 4'h8, 1'b0, W_EN_LOW,   1'b0);
            // display on
            5'd13: w = mk(SRC_CONST, 4'h0, 1'b1, W_EN_HIGH,  1'b0);
            5'd14: w = mk(SRC_CONST, 4'h0, 1'b0, W_EN_LOW,   1'b0);
            5'd15: w = mk(SRC_CONST, 4'hC, 1'b1, W_EN_HIGH,  1'b0);
            5'd16: w = mk(SRC_CONST, 4'hC, 1'b0, W_EN_LOW,   1'b0);
            // clear
            5'd17: w = mk(SRC_CONST, 4'h0, 1'b1, W_EN_HIGH,  1'b0);
            5'd18: w = mk(SRC_CONST, 4'h0, 1'b0, W_EN_LOW,   1'b0);
            5'd19: w = mk(SRC_CONST, 4'h1, 1'b1, W_EN_HIGH,  1'b0);
            5'd20: w = mk(SRC_CONST, 4'h1, 1'b0, W_SLOW,     1'b0);
            // entry mode, with the closing settle time
            5'd21: w = mk(SRC_CONST, 4'h0, 1'b1, W_EN_HIGH,  1'b0);
            5'd22: w = mk(SRC_CONST, 4'h0, 1'b0, W_EN_LOW,   1'b0);
            5'd23: w = mk(SRC_CONST, 4'h6, 1'b1, W_EN_HIGH,  1'b0);
            5'd24: w = mk(SRC_CONST, 4'h6, 1'b0, W_SLOW,     1'b1);
            // single byte from the latched value
            5'd25: w = mk(SRC_HIGH,  4'h0, 1'b1, W_EN_HIGH,  1'b0);
            5'd26: w = mk(SRC_HIGH,  4'h0, 1'b0, W_EN_LOW,   1'b0);
            5'd27: w = mk(SRC_LOW,   4'h0, 1'b1, W_EN_HIGH,  1'b0);
            5'd28: w = mk(SRC_LOW,   4'h0, 1'b0, W_COND,     1'b1);
            default: w = mk(SRC_CONST, 4'h0, 1'b0, W_EN_LOW, 1'b1);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- src/char_lcd_nibble_sequencer.sv -----
// microcoded sequencer for four-bit character lcd writes
// a request is taken when start is high and busy low; the step counter and payload
// latch at that edge, then the output registers give one step per cycle with o_strobe
// command, data and set-cursor give 4 steps, init 25;
// the rate is set by the step counter walking the microprogram table one word a cycle
// synchronous active-low reset: idle, line bases 0 and 64
`default_nettype none
module char_lcd_nibble_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_row,
    input  wire logic [6:0]  i_column,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    output logic             o_strobe,
    output logic             o_register_select,
    output logic [3:0]       o_nibble,
    output logic             o_enable,
    output logic [14:0]      o_wait_us,
    output logic             o_last
);

    logic [6:0]  r_line_one, r_line_two;
    logic        r_busy;
    logic [clns_pkg::PC_W-1:0] r_pc;
    logic [7:0]  r_byte;
    logic        r_rs;
    logic        r_slow;

    logic        r_strobe;
    logic        r_rs_out;
    logic [3:0]  r_nib_out;
    logic        r_en_out;
    logic [14:0] r_wait_out;
    logic        r_last_out;

    clns_pkg::t_uword uw;
    logic [3:0]  n_nib;
    logic [14:0] n_wait;
    logic [6:0]  base;
    logic [7:0]  addr_sum;
    logic [7:0]  n_byte;
    logic        n_rs;
    logic        n_slow;
    logic        accept;

    assign accept = start && !r_busy;
    assign uw     = clns_pkg::urom(r_pc);

    // request decode: which byte goes out and whether it needs the long settle
    always_comb begin
        base     = i_row ? r_line_two : r_line_one;
        addr_sum = {1'b0, base} + {1'b0, i_column};
        n_byte   = i_byte_value;
        n_rs     = 1'b0;
        n_slow   = 1'b0;
        unique case (clns_pkg::t_kind'(i_kind))
            clns_pkg::KIND_INIT: begin
                n_byte = i_byte_value;
            end
            clns_pkg::KIND_CMD: begin
                n_slow = (i_byte_value == clns_pkg::CMD_CLEAR) ||
                         (i_byte_value == clns_pkg::CMD_HOME);
            end
            clns_pkg::KIND_DATA: begin
                n_rs = 1'b1;
            end
            clns_pkg::KIND_CURSOR: begin
                n_byte = clns_pkg::CMD_SET_ADDR | {1'b0, addr_sum[6:0]};
            end
            default: n_byte = i_byte_value;
        endcase
    end

    // datapath driven by the control word
    always_comb begin
        unique case (uw.src)
            clns_pkg::SRC_CONST: n_nib = uw.nib;
            clns_pkg::SRC_HIGH:  n_nib = r_byte[7:4];
            clns_pkg::SRC_LOW:   n_nib = r_byte[3:0];
            default:             n_nib = uw.nib;
        endcase
        unique case (uw.wsel)
            clns_pkg::W_EN_HIGH:  n_wait = clns_pkg::WAIT_EN_HIGH;
            clns_pkg::W_EN_LOW:   n_wait = clns_pkg::WAIT_EN_LOW;
            clns_pkg::W_POWER_ON: n_wait = clns_pkg::WAIT_POWER_ON;
            clns_pkg::W_WAKE_ONE: n_wait = clns_pkg::WAIT_WAKE_ONE;
            clns_pkg::W_WAKE_TWO: n_wait = clns_pkg::WAIT_WAKE_TWO;
            clns_pkg::W_SLOW:     n_wait = clns_pkg::WAIT_SLOW;
            clns_pkg::W_COND:     n_wait = r_slow ? clns_pkg::WAIT_SLOW
                                                  : clns_pkg::WAIT_EN_LOW;
            default:              n_wait = clns_pkg::WAIT_EN_LOW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_one <= 7'd0;
            r_line_two <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_line_two <= i_cfg_data;
            end else begin
                r_line_one <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= clns_pkg::PC_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
                r_pc   <= (clns_pkg::t_kind'(i_kind) == clns_pkg::KIND_INIT)
                          ? clns_pkg::PC_INIT : clns_pkg::PC_BYTE;
            end else if (r_busy) begin
                if (uw.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
            r_slow <= n_slow;
        end
        if (r_busy) begin
            r_rs_out   <= r_rs;
            r_nib_out  <= n_nib;
            r_en_out   <= uw.en;
            r_wait_out <= n_wait;
            r_last_out <= uw.last;
        end
    end

    assign busy              = r_busy;
    assign o_strobe          = r_strobe;
    assign o_register_select = r_rs_out;
    assign o_nibble          = r_nib_out;
    assign o_enable          = r_en_out;
    assign o_wait_us         = r_wait_out;
    assign o_last            = r_last_out;

endmodule
`default_nettype wire
